FILE: design/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue
// job entry, request and response beat layouts, status codes
// no dependencies
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_POPPED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ADD = 1'b0,
      ACT_POP = 1'b1
   } action_type;

   typedef struct packed {
      logic signed [15:0] prio;
      logic [15:0]        tag;
      logic [7:0]         owner;
   } job_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] priority_req;
      logic [15:0]        job_tag;
      logic [7:0]         owner_id;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] out_priority;
      logic [15:0]        out_tag;
      logic [7:0]         out_owner;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic    is_pop;
      job_type job;
   } cmd_type;

endpackage

FILE: design/stable_priority_queue.sv
// Stable priority queue for print jobs: 16-entry job store, FIFO tie break.
// Request side is a queue: a beat is taken when req_push is high and
// req_full is low. An add beat appends a job; a pop beat removes the job of
// greatest signed priority, the earliest-added among equal priorities.
// Response side is a queue: the oldest result sits on rsp_data while
// rsp_empty is low and leaves when rsp_pop is high at that edge.
// Every request beat yields exactly one response beat, in request order.
// An add or an empty pop goes from IDLE straight to EMIT. A pop with jobs
// held runs SCAN (skipped for a single job), checking one store entry per
// cycle for the maximum, then SHIFT to close the gap, then EMIT. The engine
// takes no new command until its result enters the result queue.
// Two request beats and two result beats can wait in the side queues.
// When the receiver stalls, results fill the result queue, the engine holds
// its finished result, then the command queue fills and req_full rises.
// Synchronous reset empties both queues and the job store.
// Depends on spq_pkg, spq_front, spq_engine and spq_rsp_queue.
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  spq_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   logic    res_push;
   logic    res_full;
   rsp_type res_data;

   // front: accept and classify
   spq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // back: store, scan and compaction
   spq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_full  (res_full)
   );

   // result queue toward the response port
   spq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_full  (res_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/spq_front.sv
// spq_front: accepts request beats, classifies them, holds them in a
// two-entry command queue for the execution engine
// depends on spq_pkg
module spq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  spq_pkg::req_type req_data,
   output logic             cmd_valid,
   output spq_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import spq_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;
   cmd_type     cmd_new;

   // classify the incoming beat
   always_comb begin
      cmd_new.is_pop    = (req_data.action == ACT_POP);
      cmd_new.job.prio  = req_data.priority_req;
      cmd_new.job.tag   = req_data.job_tag;
      cmd_new.job.owner = req_data.owner_id;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: design/spq_engine.sv
// spq_engine: job store and sequencer; appends jobs, scans for the
// highest priority, compacts the store and issues one result per command
// depends on spq_pkg
module spq_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  spq_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             res_push,
   output spq_pkg::rsp_type res_data,
   input  logic             res_full
);
   import spq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   job_type          store_ff [QUEUE_DEPTH];
   job_type          store_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   job_type          best_ff, best_in;
   status_type       status_ff, status_in;
   job_type          scan_job;
   logic [CNT_W-1:0] last_idx;

   assign scan_job = store_ff[scan_ff];
   assign last_idx = count_ff - CNT_W'(1);
   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      status_in   = status_ff;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         store_in[j] = store_ff[j];
      end
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (!cmd.is_pop) begin
                  // append behind held jobs unless full
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     store_in[count_ff[IDX_W-1:0]] = cmd.job;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = ST_ADDED;
                  end
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_EMIT;
               end else begin
                  // first job is the initial best
                  best_idx_in = '0;
                  best_in     = store_ff[0];
                  scan_in     = IDX_W'(1);
                  status_in   = ST_POPPED;
                  state_in    = (count_ff == CNT_W'(1)) ? S_SHIFT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // strictly greater keeps the earliest among equals
            if (scan_job.prio > best_ff.prio) begin
               best_idx_in = scan_ff;
               best_in     = scan_job;
            end
            scan_in = scan_ff + IDX_W'(1);
            if (CNT_W'(scan_ff) == last_idx) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // close the gap left by the removed job
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
               if (IDX_W'(j) >= best_idx_ff) begin
                  store_in[j] = store_ff[j+1];
               end
            end
            count_in = count_ff - CNT_W'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!res_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result beat
   always_comb begin
      res_push           = (state_ff == S_EMIT) && !res_full;
      res_data.status    = status_ff;
      res_data.occupancy = OCC_W'(count_ff);
      if (status_ff == ST_POPPED) begin
         res_data.out_priority = best_ff.prio;
         res_data.out_tag      = best_ff.tag;
         res_data.out_owner    = best_ff.owner;
      end else begin
         res_data.out_priority = '0;
         res_data.out_tag      = '0;
         res_data.out_owner    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload and scan registers, no reset
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      status_ff   <= status_in;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         store_ff[j] <= store_in[j];
      end
   end

endmodule

FILE: design/spq_rsp_queue.sv
// spq_rsp_queue: two-entry result queue between the engine and the
// response port, so results wait without stalling the engine at once
// depends on spq_pkg
module spq_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_push,
   input  spq_pkg::rsp_type res_data,
   output logic             res_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   rsp_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign res_full  = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_push   = res_push && !res_full;
   assign do_pop    = rsp_pop && !rsp_empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule
